// ===== src/yrbd_pkg.sv =====
// yrbd_pkg: shared types, constants and register codes for the region box decoder
// no dependencies; imported by every module of the block except yrbd_div
package yrbd_pkg;

   localparam int MAX_GRID_DEF      = 64;
   localparam int SIG_DEPTH_DEF     = 1024;
   localparam int EXP_DEPTH_DEF     = 1024;

   localparam int CSR_AW            = 5;
   localparam int CSR_DW            = 32;
   localparam int REQ_TDATA_W       = 152;
   localparam int RSP_TDATA_W       = 80;

   localparam int QUEUE_DEPTH       = 2;
   localparam int QPTR_W            = 1;

   localparam int DIV_W             = 32;

   localparam logic KIND_HEADER     = 1'b0;
   localparam logic KIND_CLASS      = 1'b1;

   localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
   localparam logic [6:0]  GRID_SIZE_RST    = 7'd13;
   localparam logic [15:0] OBJ_THR_RST      = 16'd19661;
   localparam logic [15:0] CONF_THR_RST     = 16'd19661;
   localparam logic [8:0]  NUM_CLASSES_RST  = 9'd20;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH    = 3'd0,
      REG_FRAME_HEIGHT   = 3'd1,
      REG_GRID_SIZE      = 3'd2,
      REG_OBJ_THRESHOLD  = 3'd3,
      REG_CONF_THRESHOLD = 3'd4,
      REG_NUM_CLASSES    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [11:0] frame_width;
      logic [11:0] frame_height;
      logic [6:0]  grid_size;
      logic [15:0] obj_threshold;
      logic [15:0] conf_threshold;
      logic [8:0]  num_classes;
   } cfg_type;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] logit_tx;
      logic signed [15:0] logit_ty;
      logic signed [15:0] logit_tw;
      logic signed [15:0] logit_th;
      logic signed [15:0] logit_obj;
      logic [5:0]         cell_col;
      logic [5:0]         cell_row;
      logic [15:0]        anchor_width;
      logic [15:0]        anchor_height;
      logic [7:0]         class_index;
      logic signed [15:0] class_logit;
   } item_type;

endpackage

// ===== src/yrbd_div.sv =====
// yrbd_div: restoring serial divider, one quotient bit per cycle
// depends on nothing but its parameters
module yrbd_div #(
   parameter int DW = 32,
   parameter int VW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      ge      = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[VW-1:0] : trial[VW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/yrbd_front.sv =====
// yrbd_front: takes input words, drops out-of-range class words, queues the rest
// depends on yrbd_pkg
module yrbd_front
   import yrbd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // tx, ty, tw, th, obj, col, row, aw, ah, class_index, class_logit
   input  logic                   req_tuser,  // kind
   output logic                   q_valid,
   output item_type               q_item,
   input  logic                   q_pop
);

   item_type            in_item;
   item_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                keep;
   logic                push;

   always_comb begin
      in_item.kind          = req_tuser;
      in_item.logit_tx      = req_tdata[15:0];
      in_item.logit_ty      = req_tdata[31:16];
      in_item.logit_tw      = req_tdata[47:32];
      in_item.logit_th      = req_tdata[63:48];
      in_item.logit_obj     = req_tdata[79:64];
      in_item.cell_col      = req_tdata[85:80];
      in_item.cell_row      = req_tdata[91:86];
      in_item.anchor_width  = req_tdata[107:92];
      in_item.anchor_height = req_tdata[123:108];
      in_item.class_index   = req_tdata[131:124];
      in_item.class_logit   = req_tdata[147:132];
   end

   assign keep       = (in_item.kind == KIND_HEADER) ||
                       ({1'b0, in_item.class_index} < cfg.num_classes);
   assign req_tready = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready && keep;
   assign q_valid    = count_ff != '0;
   assign q_item     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/yrbd_back.sv =====
// yrbd_back: sequencer that decodes headers and scores class words, with output register
// depends on yrbd_pkg and yrbd_div
module yrbd_back
   import yrbd_pkg::*;
#(
   parameter int MAX_GRID            = MAX_GRID_DEF,
   parameter int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF,
   parameter int EXP_TABLE_DEPTH     = EXP_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   q_valid,
   input  item_type               q_item,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // left, top, width, height, confidence, class
);

   localparam int SW = $clog2(SIGMOID_TABLE_DEPTH);
   localparam int EW = $clog2(EXP_TABLE_DEPTH);
   localparam int GW = $clog2(MAX_GRID + 1);

   typedef logic [15:0] sig_tab_type [SIGMOID_TABLE_DEPTH];
   typedef logic [27:0] exp_tab_type [EXP_TABLE_DEPTH];

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_OBJ    = 14'b00000000000010,
      ST_LOOK   = 14'b00000000000100,
      ST_MUL    = 14'b00000000001000,
      ST_DIFF   = 14'b00000000010000,
      ST_PRODS  = 14'b00000000100000,
      ST_STARTS = 14'b00000001000000,
      ST_WAITS  = 14'b00000010000000,
      ST_PRODE  = 14'b00000100000000,
      ST_STARTE = 14'b00001000000000,
      ST_WAITE  = 14'b00010000000000,
      ST_CSIG   = 14'b00100000000000,
      ST_CMUL   = 14'b01000000000000,
      ST_EMIT   = 14'b10000000000000
   } state_type;

   function automatic logic [63:0] series_q24(input logic [8:0] f);
      logic [63:0] term;
      logic [63:0] sum;
      term = 64'd1 << 24;
      sum  = term;
      term = term * f / 256;   sum = sum + term;
      term = term * f / 512;   sum = sum + term;
      term = term * f / 768;   sum = sum + term;
      term = term * f / 1024;  sum = sum + term;
      term = term * f / 1280;  sum = sum + term;
      term = term * f / 1536;  sum = sum + term;
      term = term * f / 1792;  sum = sum + term;
      term = term * f / 2048;  sum = sum + term;
      term = term * f / 2304;  sum = sum + term;
      term = term * f / 2560;  sum = sum + term;
      term = term * f / 2816;  sum = sum + term;
      term = term * f / 3072;  sum = sum + term;
      return sum;
   endfunction

   localparam logic [63:0] E1_Q24 = series_q24(9'd256);

   function automatic logic [31:0] exp_q16(input int x);
      int          xs;
      int          n;
      logic [63:0] v;
      xs = x + 2048;
      n  = (xs >>> 8) - 8;
      v  = series_q24(9'(xs & 255));
      for (int i = 0; i < 8; i++) begin
         if (i < n) begin
            v = (v * E1_Q24) >> 24;
         end else if (i < -n) begin
            v = (v << 24) / E1_Q24;
         end
      end
      return v[39:8];
   endfunction

   function automatic sig_tab_type build_sig();
      sig_tab_type t;
      int          p;
      logic [63:0] den;
      logic [63:0] rem;
      logic [63:0] q;
      logic [63:0] num;
      num = 64'd1 << 32;
      for (int k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin
         p   = -2048 + (k * 4096) / SIGMOID_TABLE_DEPTH;
         den = 64'(exp_q16(-p)) + 64'd65536;
         rem = '0;
         q   = '0;
         for (int b = 32; b >= 0; b--) begin
            rem = (rem << 1) | 64'(num[b]);
            if (rem >= den) begin
               rem  = rem - den;
               q[b] = 1'b1;
            end
         end
         t[k] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
      end
      return t;
   endfunction

   function automatic exp_tab_type build_exp();
      exp_tab_type t;
      int          p;
      logic [31:0] e;
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         p    = -2048 + (k * 4096) / EXP_TABLE_DEPTH;
         e    = exp_q16(p);
         t[k] = e[27:0];
      end
      return t;
   endfunction

   localparam sig_tab_type SIG_TAB = build_sig();
   localparam exp_tab_type EXP_TAB = build_exp();

   function automatic logic [11:0] logit_offset(input logic signed [15:0] x);
      logic signed [15:0] s;
      s = x + 16'sd2048;
      if (x < -16'sd2048) begin
         return 12'd0;
      end else if (x > 16'sd2047) begin
         return 12'd4095;
      end
      return s[11:0];
   endfunction

   function automatic logic [SW-1:0] sig_index(input logic signed [15:0] x);
      logic [24:0] prod;
      prod = 25'(logit_offset(x)) * 25'(SIGMOID_TABLE_DEPTH);
      return prod[12 +: SW];
   endfunction

   function automatic logic [EW-1:0] exp_index(input logic signed [15:0] x);
      logic [24:0] prod;
      prod = 25'(logit_offset(x)) * 25'(EXP_TABLE_DEPTH);
      return prod[12 +: EW];
   endfunction

   state_type            state_ff, state_in;
   item_type             item_ff, item_in;
   logic                 axis_ff, axis_in;
   logic                 passed_ff, passed_in;
   logic [15:0]          obj_ff, obj_in;
   logic signed [13:0]   held_left_ff, held_left_in;
   logic signed [13:0]   held_top_ff, held_top_in;
   logic [13:0]          held_width_ff, held_width_in;
   logic [13:0]          held_height_ff, held_height_in;
   logic [21:0]          cq_ff, cq_in;
   logic [27:0]          ew_ff, ew_in;
   logic [35:0]          sq_ff, sq_in;
   logic [35:0]          mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [47:0]          prod_ff, prod_in;
   logic [15:0]          sig_ff, sig_in;
   logic [15:0]          conf_ff, conf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [15:0]   sig_x;
   logic [15:0]          sig_val;
   logic [27:0]          exp_val;
   logic [5:0]           grid_pos;
   logic [15:0]          anchor;
   logic [11:0]          frame;
   logic [GW-1:0]        g_eff;
   logic [43:0]          sq_full;
   logic signed [37:0]   diff;
   logic [37:0]          diff_abs;
   logic [35:0]          mul_a;
   logic [31:0]          conf_full;
   logic                 div_start;
   logic [DIV_W-1:0]     div_dividend;
   logic                 div_busy;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quo;
   logic signed [13:0]   start_val;
   logic [13:0]          extent_val;
   logic                 rsp_load;

   yrbd_div #(
      .DW (DIV_W),
      .VW (GW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (g_eff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      case (state_ff)
         ST_OBJ:  sig_x = item_ff.logit_obj;
         ST_LOOK: sig_x = axis_ff ? item_ff.logit_ty : item_ff.logit_tx;
         default: sig_x = item_ff.class_logit;
      endcase
      sig_val  = SIG_TAB[sig_index(sig_x)];
      exp_val  = EXP_TAB[exp_index(axis_ff ? item_ff.logit_th : item_ff.logit_tw)];
      grid_pos = axis_ff ? item_ff.cell_row : item_ff.cell_col;
      anchor   = axis_ff ? item_ff.anchor_height : item_ff.anchor_width;
      frame    = axis_ff ? cfg.frame_height : cfg.frame_width;

      if (cfg.grid_size == 7'd0) begin
         g_eff = GW'(1);
      end else if (32'(cfg.grid_size) > MAX_GRID) begin
         g_eff = GW'(MAX_GRID);
      end else begin
         g_eff = GW'(cfg.grid_size);
      end

      sq_full   = 44'(ew_ff) * 44'(anchor);
      diff      = $signed(38'({cq_ff, 1'b0})) - $signed(38'(sq_ff));
      diff_abs  = diff[37] ? 38'(-diff) : 38'(diff);
      mul_a     = (state_ff == ST_PRODS) ? mag_ff : sq_ff;
      conf_full = 32'(obj_ff) * 32'(sig_ff);

      div_start    = (state_ff == ST_STARTS) || (state_ff == ST_STARTE);
      div_dividend = (state_ff == ST_STARTS) ? DIV_W'(prod_ff[47:17]) : prod_ff[47:16];

      if (!neg_ff) begin
         start_val = (div_quo > 32'd8191) ? 14'sd8191 : $signed(div_quo[13:0]);
      end else begin
         start_val = (div_quo > 32'd8192) ? $signed(14'h2000) : $signed(14'd0 - div_quo[13:0]);
      end
      extent_val = (div_quo > 32'd16383) ? 14'd16383 : div_quo[13:0];
   end

   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready) &&
                     (conf_ff > cfg.conf_threshold);

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      axis_in        = axis_ff;
      passed_in      = passed_ff;
      obj_in         = obj_ff;
      held_left_in   = held_left_ff;
      held_top_in    = held_top_ff;
      held_width_in  = held_width_ff;
      held_height_in = held_height_ff;
      cq_in          = cq_ff;
      ew_in          = ew_ff;
      sq_in          = sq_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      prod_in        = prod_ff;
      sig_in         = sig_ff;
      conf_in        = conf_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               item_in = q_item;
               if (q_item.kind == KIND_HEADER) begin
                  state_in = ST_OBJ;
               end else if (passed_ff) begin
                  state_in = ST_CSIG;
               end
            end
         end
         ST_OBJ: begin
            obj_in    = sig_val;
            passed_in = sig_val >= cfg.obj_threshold;
            axis_in   = 1'b0;
            state_in  = (sig_val >= cfg.obj_threshold) ? ST_LOOK : ST_IDLE;
         end
         ST_LOOK: begin
            cq_in    = {grid_pos, 16'h0000} + 22'(sig_val);
            ew_in    = exp_val;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            sq_in    = sq_full[43:8];
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            neg_in   = diff[37];
            mag_in   = diff_abs[35:0];
            state_in = ST_PRODS;
         end
         ST_PRODS: begin
            prod_in  = 48'(mul_a) * 48'(frame);
            state_in = ST_STARTS;
         end
         ST_STARTS: begin
            state_in = ST_WAITS;
         end
         ST_WAITS: begin
            if (div_done) begin
               if (axis_ff) begin
                  held_top_in = start_val;
               end else begin
                  held_left_in = start_val;
               end
               state_in = ST_PRODE;
            end
         end
         ST_PRODE: begin
            prod_in  = 48'(mul_a) * 48'(frame);
            state_in = ST_STARTE;
         end
         ST_STARTE: begin
            state_in = ST_WAITE;
         end
         ST_WAITE: begin
            if (div_done) begin
               if (axis_ff) begin
                  held_height_in = extent_val;
                  state_in       = ST_IDLE;
               end else begin
                  held_width_in = extent_val;
                  axis_in       = 1'b1;
                  state_in      = ST_LOOK;
               end
            end
         end
         ST_CSIG: begin
            sig_in   = sig_val;
            state_in = ST_CMUL;
         end
         ST_CMUL: begin
            conf_in  = conf_full[31:16];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (conf_ff <= cfg.conf_threshold) begin
               state_in = ST_IDLE;
            end else if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {item_ff.class_index, conf_ff, held_height_ff,
                               held_width_ff, held_top_ff, held_left_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      cq_ff       <= cq_in;
      ew_ff       <= ew_in;
      sq_ff       <= sq_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      sig_ff      <= sig_in;
      conf_ff     <= conf_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         axis_ff        <= 1'b0;
         passed_ff      <= 1'b0;
         obj_ff         <= '0;
         held_left_ff   <= '0;
         held_top_ff    <= '0;
         held_width_ff  <= '0;
         held_height_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         axis_ff        <= axis_in;
         passed_ff      <= passed_in;
         obj_ff         <= obj_in;
         held_left_ff   <= held_left_in;
         held_top_ff    <= held_top_in;
         held_width_ff  <= held_width_in;
         held_height_ff <= held_height_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE)
      else $error("queue popped outside idle");
   a_emit_passed: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> passed_ff)
      else $error("detection from a rejected cell");
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");
   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(held_width_ff) && $stable(held_height_ff))
      else $error("held box changed outside header decode");
`endif

endmodule

// ===== src/yolo_region_box_decoder.sv =====
// Region-layer box decoder. Words enter on req (tuser 0 is a cell header, 1 a class word)
// and detections leave on rsp. A header whose objectness fails the threshold ends after
// the objectness lookup; one that passes goes on to decode both axes, its time set by the
// one serial divider that divides the four box values by the grid size one quotient bit
// per cycle. A class word passes lookup, multiply, compare and output in the back end,
// is dropped in the back end while no cell has passed, and may wait for the
// output register to drain; a class word with an index at or above num_classes is
// dropped on input and takes no back-end time. A two-word queue lets input words be
// taken while the back end is busy. Write registers only while no word is in flight.
// Depends on yrbd_pkg, yrbd_front, yrbd_back and yrbd_div.
module yolo_region_box_decoder
   import yrbd_pkg::*;
#(
   parameter int MAX_GRID            = MAX_GRID_DEF,
   parameter int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF,
   parameter int EXP_TABLE_DEPTH     = EXP_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tx, ty, tw, th, obj, col, row, aw, ah, class_index, class_logit
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,  // kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // left, top, width, height, confidence, class
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type csr_index;
   logic          csr_write;
   logic          q_valid;
   item_type      q_item;
   logic          q_pop;

   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH:    cfg_in.frame_width    = csr_pwdata[11:0];
            REG_FRAME_HEIGHT:   cfg_in.frame_height   = csr_pwdata[11:0];
            REG_GRID_SIZE:      cfg_in.grid_size      = csr_pwdata[6:0];
            REG_OBJ_THRESHOLD:  cfg_in.obj_threshold  = csr_pwdata[15:0];
            REG_CONF_THRESHOLD: cfg_in.conf_threshold = csr_pwdata[15:0];
            REG_NUM_CLASSES:    cfg_in.num_classes    = csr_pwdata[8:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
      case (csr_index)
         REG_FRAME_WIDTH:    csr_prdata = CSR_DW'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT:   csr_prdata = CSR_DW'(cfg_ff.frame_height);
         REG_GRID_SIZE:      csr_prdata = CSR_DW'(cfg_ff.grid_size);
         REG_OBJ_THRESHOLD:  csr_prdata = CSR_DW'(cfg_ff.obj_threshold);
         REG_CONF_THRESHOLD: csr_prdata = CSR_DW'(cfg_ff.conf_threshold);
         REG_NUM_CLASSES:    csr_prdata = CSR_DW'(cfg_ff.num_classes);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width    <= FRAME_WIDTH_RST;
         cfg_ff.frame_height   <= FRAME_HEIGHT_RST;
         cfg_ff.grid_size      <= GRID_SIZE_RST;
         cfg_ff.obj_threshold  <= OBJ_THR_RST;
         cfg_ff.conf_threshold <= CONF_THR_RST;
         cfg_ff.num_classes    <= NUM_CLASSES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   yrbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   yrbd_back #(
      .MAX_GRID            (MAX_GRID),
      .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH),
      .EXP_TABLE_DEPTH     (EXP_TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== bench/yrbd_detection_checker.sv =====
// yrbd_detection_checker: watches the request, response and register ports of the
// region box decoder, predicts each detection and compares it with the response word
// depends on yrbd_pkg
module yrbd_detection_checker
   import yrbd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   output int                     mismatches,
   output int                     outstanding
);

   typedef struct packed {
      logic [13:0] left;
      logic [13:0] top;
      logic [13:0] width;
      logic [13:0] height;
      logic [15:0] confidence;
      logic [7:0]  class_id;
   } detection_type;

   localparam int DEPTH_SIG = SIG_DEPTH_DEF;
   localparam int DEPTH_EXP = EXP_DEPTH_DEF;

   longint unsigned sigmoid_rom [DEPTH_SIG];
   longint unsigned exp_rom [DEPTH_EXP];

   cfg_type cfg;
   logic cell_ok;
   logic [15:0] cell_obj;
   logic signed [13:0] box_left, box_top;
   logic [13:0] box_width, box_height;
   detection_type pending_dets [$];

   assign outstanding = pending_dets.size();

   function automatic longint unsigned taylor_q24(longint unsigned f);
      longint unsigned term, sum;
      term = 64'd1 << 24;
      sum = term;
      for (int k = 1; k <= 12; k++) begin
         term = term * f / (256 * k);
         sum += term;
      end
      return sum;
   endfunction

   function automatic longint unsigned exp_fixed(int x);
      longint unsigned xs, v, e1;
      int n;
      xs = x + 2048;
      n = int'(xs >> 8) - 8;
      v = taylor_q24(xs & 255);
      e1 = taylor_q24(256);
      if (n > 0) begin
         for (int i = 0; i < n; i++) v = (v * e1) >> 24;
      end else begin
         for (int i = 0; i < -n; i++) v = (v << 24) / e1;
      end
      return v >> 8;
   endfunction

   initial begin
      int p;
      longint unsigned s;
      for (int k = 0; k < DEPTH_SIG; k++) begin
         p = -2048 + (k * 4096) / DEPTH_SIG;
         s = (64'd1 << 32) / (65536 + exp_fixed(-p));
         sigmoid_rom[k] = (s > 65535) ? 65535 : s;
      end
      for (int k = 0; k < DEPTH_EXP; k++) begin
         p = -2048 + (k * 4096) / DEPTH_EXP;
         exp_rom[k] = exp_fixed(p);
      end
   end

   function automatic int clamp_index(logic signed [15:0] x, int depth);
      int v;
      v = x;
      if (v < -2048) v = -2048;
      if (v > 2047) v = 2047;
      return ((v + 2048) * depth) >> 12;
   endfunction

   function automatic longint sat(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic decode_axis(input logic [5:0] grid_pos, input logic signed [15:0] t_off,
                              input logic signed [15:0] t_size, input logic [15:0] anchor,
                              input longint g, input logic [11:0] frame,
                              output logic [13:0] start, output logic [13:0] extent);
      longint cq, sq, den, s, e;
      cq = longint'(grid_pos) * 65536
           + longint'(sigmoid_rom[clamp_index(t_off, DEPTH_SIG)]);
      sq = longint'((exp_rom[clamp_index(t_size, DEPTH_EXP)] * anchor) >> 8);
      den = g * 65536;
      s = (2 * cq - sq) * longint'(frame) / (2 * den);
      e = sq * longint'(frame) / den;
      start = 14'(sat(s, -8192, 8191));
      extent = 14'(sat(e, 0, 16383));
   endtask

   task automatic predict_word(input item_type it);
      longint g;
      logic [15:0] obj, conf;
      detection_type d;
      if (it.kind == KIND_HEADER) begin
         obj = 16'(sigmoid_rom[clamp_index(it.logit_obj, DEPTH_SIG)]);
         g = cfg.grid_size;
         if (g == 0) g = 1;
         if (g > MAX_GRID_DEF) g = MAX_GRID_DEF;
         cell_obj = obj;
         cell_ok = obj >= cfg.obj_threshold;
         if (cell_ok) begin
            decode_axis(it.cell_col, it.logit_tx, it.logit_tw, it.anchor_width, g,
                        cfg.frame_width, box_left, box_width);
            decode_axis(it.cell_row, it.logit_ty, it.logit_th, it.anchor_height, g,
                        cfg.frame_height, box_top, box_height);
         end
      end else if (cell_ok && it.class_index < cfg.num_classes) begin
         conf = 16'((longint'(cell_obj)
                * longint'(sigmoid_rom[clamp_index(it.class_logit, DEPTH_SIG)])) >> 16);
         if (conf > cfg.conf_threshold) begin
            d.left = box_left;
            d.top = box_top;
            d.width = box_width;
            d.height = box_height;
            d.confidence = conf;
            d.class_id = it.class_index;
            pending_dets = {pending_dets, d};
         end
      end
   endtask

   task automatic compare_word(input detection_type got);
      detection_type want;
      if (pending_dets.size() == 0) begin
         $display("%0t: unexpected word %h", $time, got);
         mismatches++;
      end else begin
         want = pending_dets.pop_front();
         if (got != want) begin
            $display("%0t: mismatch expected l=%0d t=%0d w=%0d h=%0d c=%0d k=%0d",
                     $time, $signed(want.left), $signed(want.top), want.width,
                     want.height, want.confidence, want.class_id);
            $display("%0t:          actual   l=%0d t=%0d w=%0d h=%0d c=%0d k=%0d",
                     $time, $signed(got.left), $signed(got.top), got.width,
                     got.height, got.confidence, got.class_id);
            mismatches++;
         end
      end
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      item_type it;
      if (reset) begin
         cfg.frame_width <= FRAME_WIDTH_RST;
         cfg.frame_height <= FRAME_HEIGHT_RST;
         cfg.grid_size <= GRID_SIZE_RST;
         cfg.obj_threshold <= OBJ_THR_RST;
         cfg.conf_threshold <= CONF_THR_RST;
         cfg.num_classes <= NUM_CLASSES_RST;
         cell_ok = 1'b0;
         cell_obj = '0;
         box_left = '0;
         box_top = '0;
         box_width = '0;
         box_height = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr >> 2)
               REG_FRAME_WIDTH:    cfg.frame_width <= csr_pwdata[11:0];
               REG_FRAME_HEIGHT:   cfg.frame_height <= csr_pwdata[11:0];
               REG_GRID_SIZE:      cfg.grid_size <= csr_pwdata[6:0];
               REG_OBJ_THRESHOLD:  cfg.obj_threshold <= csr_pwdata[15:0];
               REG_CONF_THRESHOLD: cfg.conf_threshold <= csr_pwdata[15:0];
               REG_NUM_CLASSES:    cfg.num_classes <= csr_pwdata[8:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            compare_word({rsp_tdata[13:0], rsp_tdata[27:14], rsp_tdata[41:28],
                          rsp_tdata[55:42], rsp_tdata[71:56], rsp_tdata[79:72]});
         end
         if (req_tvalid && req_tready) begin
            it.kind = req_tuser;
            it.logit_tx = req_tdata[15:0];
            it.logit_ty = req_tdata[31:16];
            it.logit_tw = req_tdata[47:32];
            it.logit_th = req_tdata[63:48];
            it.logit_obj = req_tdata[79:64];
            it.cell_col = req_tdata[85:80];
            it.cell_row = req_tdata[91:86];
            it.anchor_width = req_tdata[107:92];
            it.anchor_height = req_tdata[123:108];
            it.class_index = req_tdata[131:124];
            it.class_logit = req_tdata[147:132];
            predict_word(it);
         end
      end
   end

endmodule

// ===== bench/yolo_region_box_decoder_tb.sv =====
// yolo_region_box_decoder_tb: drives cell headers and class words into the decoder
// through several register settings and idling phases; the checker judges the output
// depends on yrbd_pkg, yrbd_detection_checker and the decoder rtl
module yolo_region_box_decoder_tb;
   import yrbd_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 600;
   localparam int HOLD_LEN = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   int mismatches, outstanding;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_request = 0;
   int hold_seen = 0;
   int hold_cycles = 0;
   int cycle_count = 0;
   int class_span = 20;

   always #1 clock = ~clock;

   yolo_region_box_decoder u_top (.*);

   yrbd_detection_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_cycles = HOLD_LEN;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [REQ_TDATA_W-1:0] pack_word(item_type it);
      return {4'b0, it.class_logit, it.class_index, it.anchor_height, it.anchor_width,
              it.cell_row, it.cell_col, it.logit_obj, it.logit_th, it.logit_tw,
              it.logit_ty, it.logit_tx};
   endfunction

   task automatic send_word(input item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= pack_word(it);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(input int fw, input int fh, input int gs, input int othr,
                           input int cthr, input int ncls);
      wait_idle();
      csr_write(REG_FRAME_WIDTH, fw);
      csr_write(REG_FRAME_HEIGHT, fh);
      csr_write(REG_GRID_SIZE, gs);
      csr_write(REG_OBJ_THRESHOLD, othr);
      csr_write(REG_CONF_THRESHOLD, cthr);
      csr_write(REG_NUM_CLASSES, ncls);
      class_span = (ncls > 250) ? 255 : ncls + 4;
   endtask

   function automatic logic [15:0] rand_logit(int lo, int hi);
      return 16'($urandom_range(hi - lo) + lo);
   endfunction

   function automatic item_type wild_word();
      logic [159:0] r;
      item_type it;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom};
      it = r[$bits(item_type)-1:0];
      return it;
   endfunction

   function automatic item_type header_word();
      item_type it;
      it = wild_word();
      it.kind = KIND_HEADER;
      it.logit_tx = rand_logit(-1024, 1024);
      it.logit_ty = rand_logit(-1024, 1024);
      it.logit_tw = rand_logit(-600, 600);
      it.logit_th = rand_logit(-600, 600);
      it.logit_obj = rand_logit(-600, 2047);
      it.cell_col = 6'($urandom_range(15));
      it.cell_row = 6'($urandom_range(15));
      it.anchor_width = 16'($urandom_range(2048, 32));
      it.anchor_height = 16'($urandom_range(2048, 32));
      return it;
   endfunction

   function automatic item_type class_word();
      item_type it;
      it = wild_word();
      it.kind = KIND_CLASS;
      it.class_index = 8'($urandom_range(class_span));
      it.class_logit = rand_logit(-1024, 2047);
      return it;
   endfunction

   task automatic send_cells(input int count);
      int sent;
      item_type it;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) == 0) begin
            send_word(wild_word());
            sent++;
         end else begin
            send_word(header_word());
            sent++;
            repeat ($urandom_range(8, 1)) begin
               it = class_word();
               send_word(it);
               sent++;
            end
         end
      end
   endtask

   task automatic send_directed();
      item_type it;
      send_word(class_word());
      it = header_word();
      it.logit_obj = 16'sh7fff;
      it.logit_tx = 16'sh8000;
      it.logit_ty = 16'sh7fff;
      it.logit_tw = 16'sh7fff;
      it.logit_th = 16'sh8000;
      it.anchor_width = 16'hffff;
      it.anchor_height = 16'h0000;
      it.cell_col = 6'd63;
      it.cell_row = 6'd0;
      send_word(it);
      it = class_word();
      it.class_index = 8'd0;
      it.class_logit = 16'sh7fff;
      send_word(it);
      it.class_logit = 16'sh8000;
      send_word(it);
      it.class_index = 8'd19;
      it.class_logit = 16'sh0400;
      send_word(it);
      it.class_index = 8'd20;
      send_word(it);
      it.class_index = 8'd255;
      send_word(it);
      it = header_word();
      it.logit_tx = 16'sh7fff;
      it.logit_ty = 16'sh8000;
      it.logit_tw = 16'sh8000;
      it.logit_th = 16'sh7fff;
      it.anchor_width = 16'h0000;
      it.anchor_height = 16'hffff;
      it.cell_col = 6'd0;
      it.cell_row = 6'd63;
      it.logit_obj = 16'sh0800;
      send_word(it);
      it = class_word();
      it.class_index = 8'd3;
      it.class_logit = 16'sh0600;
      send_word(it);
      it = header_word();
      it.logit_obj = 16'sh8000;
      send_word(it);
      it = class_word();
      it.class_index = 8'd1;
      it.class_logit = 16'sh7fff;
      send_word(it);
      send_word(header_word());
      repeat (4) send_word(class_word());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();

      // extremes: zero frame, grid zero and grid above the maximum
      set_regs(0, 4095, 0, 0, 0, 256);
      send_directed();
      set_regs(4095, 0, 127, 65535, 65535, 511);
      send_directed();
      set_regs(4095, 4095, 1, 0, 0, 0);
      send_directed();

      // no idling, with a long receiver hold-off that fills the block
      set_regs(1, 4095, 64, 0, 0, 1);
      send_cells(20);
      set_regs(640, 480, 13, 19661, 19661, 20);
      hold_request = hold_request + 1;
      send_word(header_word());
      repeat (40) send_word(class_word());
      send_cells(100);

      // sender idle most of the time
      set_regs(1920, 1080, 7, 30000, 40000, 80);
      send_idle_pct = 88;
      send_cells(100);
      wait_idle();
      send_cells(20);

      // receiver stalling most of the time
      set_regs(416, 416, 64, 10000, 8000, 256);
      send_idle_pct = 0;
      recv_stall_pct = 88;
      send_cells(110);

      // both idle part of the time
      set_regs(4095, 1, 2, 0, 1000, 5);
      send_idle_pct = 35;
      recv_stall_pct = 35;
      send_cells(110);

      set_regs(300, 200, 13, 19661, 0, 20);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_cells(30);

      wait_idle();
      if (mismatches == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
